>>> src/ftwc_pkg.sv
// Package for the threshold window count FIFO: sizes, status and command codes,
// and the stage record passed from the command stage to the result stage.
// No dependencies.
package ftwc_pkg;

  localparam int DEPTH   = 1024;
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int CNT_W   = 11;
  localparam int LEN_W   = 11;
  localparam int SCORE_W = 32;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int CMP_W   = (OCC_W > LEN_W) ? OCC_W : LEN_W;
  localparam int SUM_W   = OCC_W + 1;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_CLAMP = 2'd3;

  typedef struct packed {
    logic              valid;
    logic              pop_ok;
    logic              query_ok;
    logic [STAT_W-1:0] status;
  } ftwc_stage_t;

endpackage

>>> src/ftwc_ram.sv
// Prefix count store: single-port synchronous RAM, one access per cycle, with
// registered read data. Depends on ftwc_pkg.
module ftwc_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ftwc_pkg::PTR_W-1:0] addr,
  input  logic [ftwc_pkg::CNT_W-1:0] wdata,
  output logic [ftwc_pkg::CNT_W-1:0] rdata
);
  import ftwc_pkg::*;

  logic [CNT_W-1:0] mem [DEPTH];
  logic [CNT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/ftwc_ctrl.sv
// Command stage: threshold register, ring pointers, occupancy and running
// count; drives the prefix RAM and issues the stage record. Depends on ftwc_pkg.
module ftwc_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [ftwc_pkg::CMD_W-1:0]   command,
  input  logic [ftwc_pkg::SCORE_W-1:0] score,
  input  logic [ftwc_pkg::LEN_W-1:0]   window_len,
  input  logic                         thr_we,
  input  logic [ftwc_pkg::SCORE_W-1:0] thr_data,
  output logic                         ram_we,
  output logic [ftwc_pkg::PTR_W-1:0]   ram_addr,
  output logic [ftwc_pkg::CNT_W-1:0]   ram_wdata,
  output ftwc_pkg::ftwc_stage_t        stage
);
  import ftwc_pkg::*;

  logic [SCORE_W-1:0] thr_r;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  ftwc_stage_t        stage_r, stage_nxt;

  logic [CMP_W-1:0]   len_ext;
  logic [CMP_W-1:0]   occ_ext;
  logic [OCC_W-1:0]   len_clamp;
  logic [SUM_W-1:0]   idx_sum;
  logic [SUM_W-1:0]   idx_wrap;
  logic               hit;

  assign len_ext = CMP_W'(window_len);
  assign occ_ext = CMP_W'(occ_r);
  assign hit     = $signed(score) >= $signed(thr_r);

  always_comb begin
    len_clamp = (len_ext > occ_ext) ? occ_r : OCC_W'(len_ext);
    idx_sum   = SUM_W'(head_r) + SUM_W'(len_clamp) - SUM_W'(1);
    idx_wrap  = (idx_sum >= SUM_W'(DEPTH)) ? (idx_sum - SUM_W'(DEPTH)) : idx_sum;
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    occ_nxt   = occ_r;
    total_nxt = total_r;
    ram_we    = 1'b0;
    ram_addr  = head_r;
    ram_wdata = total_r;
    stage_nxt = '0;
    if (accept) begin
      stage_nxt.valid = 1'b1;
      unique case (command)
        CMD_PUSH: begin
          if (occ_r == OCC_W'(DEPTH)) begin
            stage_nxt.status = ST_FULL;
          end else begin
            total_nxt = total_r + CNT_W'(hit);
            ram_we    = 1'b1;
            ram_addr  = tail_r;
            ram_wdata = total_nxt;
            tail_nxt  = (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
            occ_nxt   = occ_r + OCC_W'(1);
          end
        end
        CMD_POP: begin
          if (occ_r == '0) begin
            stage_nxt.status = ST_EMPTY;
          end else begin
            stage_nxt.pop_ok = 1'b1;
            ram_addr = head_r;
            head_nxt = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
            occ_nxt  = occ_r - OCC_W'(1);
          end
        end
        CMD_QUERY: begin
          if (len_ext > occ_ext) begin
            stage_nxt.status = ST_CLAMP;
          end
          if (len_clamp != '0) begin
            stage_nxt.query_ok = 1'b1;
            ram_addr = idx_wrap[PTR_W-1:0];
          end
        end
        CMD_NONE: begin
          stage_nxt.status = ST_OK;
        end
        default: begin
          stage_nxt.status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      occ_r   <= '0;
      total_r <= '0;
      stage_r <= '0;
    end else begin
      if (thr_we) begin
        thr_r <= thr_data;
      end
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      occ_r   <= occ_nxt;
      total_r <= total_nxt;
      stage_r <= stage_nxt;
    end
  end

  assign stage = stage_r;

endmodule

>>> src/ftwc_result.sv
// Result stage: holds the head base, forms the window count from the RAM read
// data and drives the result strobe. Depends on ftwc_pkg.
module ftwc_result (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ftwc_pkg::ftwc_stage_t       stage,
  input  logic [ftwc_pkg::CNT_W-1:0]  rdata,
  output logic                        out_valid,
  output logic [ftwc_pkg::CNT_W-1:0]  out_count,
  output logic [ftwc_pkg::STAT_W-1:0] out_status
);
  import ftwc_pkg::*;

  logic [CNT_W-1:0] base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (stage.valid && stage.pop_ok) begin
      base_r <= rdata;
    end
  end

  // The count is the difference of two prefixes, modulo the count width.
  assign out_count  = (stage.valid && stage.query_ok) ? (rdata - base_r) : '0;
  assign out_status = stage.status;
  assign out_valid  = stage.valid;

endmodule

>>> src/fifo_threshold_window_count.sv
// Top level of the threshold window count FIFO.
// Depends on ftwc_pkg, ftwc_ctrl, ftwc_ram and ftwc_result.
//
//   Channel  Handshake              Payload
//   -------  ---------------------  -----------------------------------------
//   in       start / busy           in_command, in_score, in_window_len
//   out      out_valid (strobe)     out_match_count, out_status
//   cfg      cfg_valid / cfg_ready  cfg_score_threshold
//
// An item accepted at one clock edge shows its result on the out ports during
// the following cycle, for exactly that cycle. Every command makes one access
// to the prefix RAM, so a new item is taken every cycle and busy stays low.
// The result comes from the registered read port of the RAM and the registered stage record.
// Reset is synchronous and clears pointers, counts and the threshold; the
// RAM needs no clearing since only written entries are ever used.
// The receiver cannot stall, so nothing backs up behind the result strobe.
module fifo_threshold_window_count (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [ftwc_pkg::CMD_W-1:0]       in_command,
  input  logic signed [ftwc_pkg::SCORE_W-1:0] in_score,
  input  logic [ftwc_pkg::LEN_W-1:0]       in_window_len,
  output logic                             out_valid,
  output logic [ftwc_pkg::CNT_W-1:0]       out_match_count,
  output logic [ftwc_pkg::STAT_W-1:0]      out_status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic signed [ftwc_pkg::SCORE_W-1:0] cfg_score_threshold
);
  import ftwc_pkg::*;

  logic             accept;
  logic             ram_we;
  logic [PTR_W-1:0] ram_addr;
  logic [CNT_W-1:0] ram_wdata;
  logic [CNT_W-1:0] ram_rdata;
  ftwc_stage_t      stage;

  // Each command fits in one RAM access, so the block is always ready.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // The command stage updates pointers and counts at the accepting edge and
  // either writes the new prefix (push) or reads a stored one (pop, query).
  ftwc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .command    (in_command),
    .score      (in_score),
    .window_len (in_window_len),
    .thr_we     (cfg_valid && cfg_ready),
    .thr_data   (cfg_score_threshold),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .stage      (stage)
  );

  // A write at one edge is visible to a read at the next edge, so an item
  // that follows a push directly sees the new prefix without forwarding.
  ftwc_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // The head base is updated by a pop at the end of its result stage, so the
  // result stage of the next item already uses it.
  ftwc_result u_result (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage      (stage),
    .rdata      (ram_rdata),
    .out_valid  (out_valid),
    .out_count  (out_match_count),
    .out_status (out_status)
  );

endmodule

>>> src/ftwc_checker.sv
// Port-level checker for the threshold window count FIFO, bound to the top
// level. Depends on ftwc_pkg and fifo_threshold_window_count.
module ftwc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic [ftwc_pkg::CMD_W-1:0]       in_command,
  input logic                             out_valid,
  input logic [ftwc_pkg::CNT_W-1:0]       out_match_count,
  input logic [ftwc_pkg::STAT_W-1:0]      out_status
);
  import ftwc_pkg::*;

  // Every accepted item gives exactly one result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result strobe without an accepted item");

  // Only a query can report a nonzero count.
  a_count_query_only: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command != CMD_QUERY) |=> (out_match_count == '0))
    else $error("nonzero count on a non-query item");

  // Full and empty status codes belong to push and pop respectively; this checks that a query reports neither.
  a_status_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_QUERY) |=>
      (out_status == ST_OK || out_status == ST_CLAMP))
    else $error("query reported a push or pop status");

endmodule

bind fifo_threshold_window_count ftwc_checker u_ftwc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_command      (in_command),
  .out_valid       (out_valid),
  .out_match_count (out_match_count),
  .out_status      (out_status)
);
